// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lsct_pkg.sv =====
package lsct_pkg;

	// Array geometry
	localparam int CHANNELS    = 17;
	localparam int SAMPLE_BITS = 10;
	localparam int CH_W        = $clog2(CHANNELS);

	// Fixed field widths
	localparam int DATA_W  = 10;
	localparam int CHAN_W  = 5;
	localparam int VEC_W   = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// Only the low SAMPLE_BITS of a reading are used
	localparam int MASK_BITS = (SAMPLE_BITS < DATA_W) ? SAMPLE_BITS : DATA_W;
	localparam logic [DATA_W-1:0] SAMPLE_MASK = DATA_W'((64'd1 << MASK_BITS) - 64'd1);

	// Register reset and index
	localparam logic [DATA_W-1:0] MARGIN_RESET = DATA_W'(10);
	localparam logic [PADDR_W-3:0] REG_MARGIN  = '0;

	// Operation codes
	typedef enum logic [1:0] {
		OP_CAL    = 2'd0,
		OP_DETECT = 2'd1,
		OP_END    = 2'd2,
		OP_LOAD   = 2'd3
	} op_t;

	// One channel's calibration entry
	typedef struct packed {
		logic [DATA_W-1:0] max_v;
		logic [DATA_W-1:0] min_v;
		logic [DATA_W-1:0] mid_v;
	} cal_entry_t;

	// Channel that drives Y bit b: 9..12, then channel 4, then 13..16
	function automatic logic [CHAN_W-1:0] y_chan(input int b);
		if (b < 4) begin
			return CHAN_W'(9 + b);
		end else if (b == 4) begin
			return CHAN_W'(4);
		end else begin
			return CHAN_W'(8 + b);
		end
	endfunction

endpackage

// ===== sv/line_sensor_calibrate_threshold.sv =====
// Line sensor calibration and detection for a sensor array of lsct_pkg::CHANNELS channels.
// One sample transfer is taken per clock: the addressed channel's min/max/midpoint entry is
// read from a synchronous RAM at acceptance, updated in stage 1 and written back as it
// advances, with the last write forwarded so that back-to-back samples on one channel see
// fresh data. A result is registered in the output register as its sample leaves stage 1
// and held there, so one more sample is taken while a result waits; input stalls only once
// the stage and the output register are both full. Throughput is one sample per cycle while
// results are taken; the read-modify-write path through the calibration RAM sets both
// latency and rate. Entries read as zero until first written (per-entry valid flops). The
// threshold margin register sits at byte address 0 of the APB port, reset value 10.
`include "assert_macros.svh"

module line_sensor_calibrate_threshold (
	input  logic                         clk,
	input  logic                         arst_n,
	// sample channel
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   operation,
	input  logic [lsct_pkg::CHAN_W-1:0]  channel,
	input  logic [lsct_pkg::DATA_W-1:0]  sample,
	// result channel
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         detected,
	output logic [lsct_pkg::DATA_W-1:0]  midpoint,
	output logic [lsct_pkg::VEC_W-1:0]   line_x,
	output logic [lsct_pkg::VEC_W-1:0]   line_y,
	// configuration port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lsct_pkg::PADDR_W-1:0] paddr,
	input  logic [lsct_pkg::PDATA_W-1:0] pwdata,
	output logic [lsct_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);

	localparam int DW = lsct_pkg::DATA_W;
	localparam int VW = lsct_pkg::VEC_W;
	localparam int CW = lsct_pkg::CH_W;
	localparam int NC = lsct_pkg::CHANNELS;

	// Configuration register
	logic [DW-1:0] margin_q;
	logic          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[lsct_pkg::PADDR_W-1:2] == lsct_pkg::REG_MARGIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= lsct_pkg::MARGIN_RESET;
		end else if (cfg_wr) begin
			margin_q <= pwdata[DW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[lsct_pkg::PADDR_W-1:2] == lsct_pkg::REG_MARGIN) begin
			prdata = lsct_pkg::PDATA_W'(margin_q);
		end
	end

	// Handshake
	logic v_s1;
	logic s1_adv;
	logic item_fire;
	logic out_valid_q;

	assign s1_adv     = v_s1 && (!out_valid_q || result_ready);
	assign item_ready = !v_s1 || s1_adv;
	assign item_fire  = item_valid && item_ready;

	// Stage 1 item registers
	lsct_pkg::op_t        op_s1;
	logic [lsct_pkg::CHAN_W-1:0] ch_s1;
	logic [DW-1:0]        smp_s1;
	logic                 ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (item_ready) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			op_s1  <= lsct_pkg::op_t'(operation);
			ch_s1  <= channel;
			smp_s1 <= sample & lsct_pkg::SAMPLE_MASK;
			ok_s1  <= ({1'b0, channel} < (lsct_pkg::CHAN_W + 1)'(NC));
		end
	end

	// Calibration RAM, registered read
	lsct_pkg::cal_entry_t mem [NC];
	lsct_pkg::cal_entry_t rd_s1;
	logic                 wr_en;
	lsct_pkg::cal_entry_t wr_data;
	logic                 rd_en;

	assign rd_en = item_fire && ({1'b0, channel} < (lsct_pkg::CHAN_W + 1)'(NC));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ch_s1[CW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_s1 <= mem[channel[CW-1:0]];
		end
	end

	// Entry written flags, last write for forwarding, seed flags, line vectors
	logic [NC-1:0]        mem_vld_q;
	logic [NC-1:0]        seeded_q;
	logic                 lw_vld_q;
	logic                 lw_cal_q;
	logic [CW-1:0]        lw_addr_q;
	lsct_pkg::cal_entry_t lw_data_q;
	logic [VW-1:0]        x_q;
	logic [VW-1:0]        y_q;

	// Current entry: never written reads zero, last write wins over RAM data
	lsct_pkg::cal_entry_t cur;
	logic                 seeded_cur;

	always_comb begin
		cur        = '0;
		seeded_cur = 1'b0;
		if (ok_s1) begin
			seeded_cur = seeded_q[ch_s1[CW-1:0]];
			if (mem_vld_q[ch_s1[CW-1:0]]) begin
				if (lw_vld_q && (lw_addr_q == ch_s1[CW-1:0])) begin
					cur = lw_data_q;
				end else begin
					cur = rd_s1;
				end
			end
		end
	end

	// Update logic
	logic [DW:0]   mm_sum;
	logic [DW:0]   thr_sum;
	logic          hit;
	logic [VW-1:0] x_nxt;
	logic [VW-1:0] y_nxt;
	logic          cal_wr;

	always_comb begin
		wr_data = cur;
		cal_wr  = 1'b0;
		wr_en   = 1'b0;
		hit     = 1'b0;
		x_nxt   = x_q;
		y_nxt   = y_q;
		thr_sum = {1'b0, smp_s1} + {1'b0, margin_q};
		mm_sum  = '0;
		case (op_s1)
			lsct_pkg::OP_CAL: begin
				if (!seeded_cur) begin
					wr_data.max_v = smp_s1;
					wr_data.min_v = smp_s1;
				end else if (smp_s1 > cur.max_v) begin
					wr_data.max_v = smp_s1;
				end else if (smp_s1 < cur.min_v) begin
					wr_data.min_v = smp_s1;
				end
				mm_sum        = {1'b0, wr_data.max_v} + {1'b0, wr_data.min_v};
				wr_data.mid_v = mm_sum[DW:1];
				wr_en         = s1_adv && ok_s1;
				cal_wr        = 1'b1;
			end
			lsct_pkg::OP_LOAD: begin
				wr_data.mid_v = smp_s1;
				wr_en         = s1_adv && ok_s1;
			end
			lsct_pkg::OP_DETECT: begin
				// s <= mid - margin, signed, is s + margin <= mid
				hit = ok_s1 && (thr_sum <= {1'b0, cur.mid_v});
				if (ok_s1) begin
					for (int b = 0; b < VW; b++) begin
						if (ch_s1 == lsct_pkg::CHAN_W'(b)) begin
							x_nxt[b] = hit;
						end
						if (ch_s1 == lsct_pkg::y_chan(b)) begin
							y_nxt[b] = hit;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// State update on stage advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q <= '0;
			seeded_q  <= '0;
			lw_vld_q  <= 1'b0;
			lw_cal_q  <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
		end else if (s1_adv) begin
			x_q <= x_nxt;
			y_q <= y_nxt;
			if (op_s1 == lsct_pkg::OP_END) begin
				seeded_q <= '0;
			end else if (op_s1 == lsct_pkg::OP_CAL && ok_s1) begin
				seeded_q[ch_s1[CW-1:0]] <= 1'b1;
			end
			if (wr_en) begin
				mem_vld_q[ch_s1[CW-1:0]] <= 1'b1;
				lw_vld_q                 <= 1'b1;
				lw_cal_q                 <= cal_wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			lw_addr_q <= ch_s1[CW-1:0];
			lw_data_q <= wr_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			detected <= hit;
			midpoint <= ok_s1 ? wr_data.mid_v : '0;
			line_x   <= x_nxt;
			line_y   <= y_nxt;
		end
	end

	assign result_valid = out_valid_q;

	// Checks
	logic end_adv;
	logic cal_in_order;

	assign end_adv      = s1_adv && (op_s1 == lsct_pkg::OP_END);
	assign cal_in_order = (lw_data_q.min_v <= lw_data_q.mid_v) &&
		(lw_data_q.mid_v <= lw_data_q.max_v);

	`ASSERT_NEXT(a_end_clears, end_adv, seeded_q == '0, "seed flags not cleared")
	`ASSERT_IMPL(a_cal_order, lw_vld_q && lw_cal_q, cal_in_order, "calibration entry out of order")
	`ASSERT_ALWAYS(a_ch4_bits, x_q[4] == y_q[4], "channel 4 bits disagree")

endmodule

// ===== tb/sv/line_sensor_calibrate_threshold_test.sv =====
module line_sensor_calibrate_threshold_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lsct_pkg::*;

	localparam int ROW_COUNT    = 25;
	localparam int PHASE_ITEMS  = 456;
	localparam int PHASES       = 4;
	localparam int QUIET_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 6;
	localparam int MAX_PRINTS   = 40;
	localparam int SAMPLE_MAX   = (1 << DATA_W) - 1;
	localparam logic [PADDR_W-1:0] MARGIN_ADDR = PADDR_W'(4 * REG_MARGIN);

	// One result transfer
	typedef struct packed {
		logic               detected;
		logic [DATA_W-1:0]  midpoint;
		logic [VEC_W-1:0]   line_x;
		logic [VEC_W-1:0]   line_y;
	} line_result_t;

	// One directed sample; want is used only where typed is set
	typedef struct packed {
		op_t                op;
		logic [CHAN_W-1:0]  ch;
		logic [DATA_W-1:0]  s;
		bit                 typed;
		line_result_t       want;
	} sample_row_t;

	localparam line_result_t ALL_ZERO = '0;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	logic [1:0]           operation    = 2'd0;
	logic [CHAN_W-1:0]    channel      = '0;
	logic [DATA_W-1:0]    sample       = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic                 detected;
	logic [DATA_W-1:0]    midpoint;
	logic [VEC_W-1:0]     line_x;
	logic [VEC_W-1:0]     line_y;
	logic                 psel         = 1'b0;
	logic                 penable      = 1'b0;
	logic                 pwrite       = 1'b0;
	logic [PADDR_W-1:0]   paddr        = '0;
	logic [PDATA_W-1:0]   pwdata       = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	// Calibration state mirror
	logic [DATA_W-1:0]    hi_cal  [CHANNELS];
	logic [DATA_W-1:0]    lo_cal  [CHANNELS];
	logic [DATA_W-1:0]    mid_cal [CHANNELS];
	logic [CHANNELS-1:0]  seeded_ch;
	logic [VEC_W-1:0]     x_bits;
	logic [VEC_W-1:0]     y_bits;
	logic [DATA_W-1:0]    margin_val;

	line_result_t pending_results [$];
	int  mismatches      = 0;
	int  results_checked = 0;
	int  hits            = 0;
	int  op_seen [4]     = '{0, 0, 0, 0};
	int  margins_used [PHASES];
	int  quiet_cycles    = 0;
	int  ready_hold      = 0;
	bit  calm            = 1'b0;

	// Directed samples: reset state, out-of-range channels, extremes, channels 0, 4, 8, 9, 12, 13 and 16
	sample_row_t directed_rows [ROW_COUNT] = '{
		'{OP_DETECT, 5'd0,  10'd0,    1'b1, ALL_ZERO},
		'{OP_CAL,    5'd31, 10'd1023, 1'b1, ALL_ZERO},
		'{OP_LOAD,   5'd17, 10'd1023, 1'b1, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd1023, 1'b0, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd0,    1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd0,  10'd0,    1'b0, ALL_ZERO},
		'{OP_CAL,    5'd4,  10'd600,  1'b0, ALL_ZERO},
		'{OP_CAL,    5'd4,  10'd200,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd4,  10'd0,    1'b0, ALL_ZERO},
		'{OP_LOAD,   5'd16, 10'd1023, 1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd16, 10'd1013, 1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd16, 10'd1014, 1'b0, ALL_ZERO},
		'{OP_LOAD,   5'd9,  10'd500,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd9,  10'd0,    1'b0, ALL_ZERO},
		'{OP_LOAD,   5'd13, 10'd700,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd13, 10'd5,    1'b0, ALL_ZERO},
		'{OP_LOAD,   5'd8,  10'd300,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd8,  10'd290,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd17, 10'd0,    1'b0, ALL_ZERO},
		'{OP_END,    5'd31, 10'd0,    1'b0, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd700,  1'b0, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd800,  1'b0, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd600,  1'b0, ALL_ZERO},
		'{OP_CAL,    5'd0,  10'd650,  1'b0, ALL_ZERO},
		'{OP_DETECT, 5'd12, 10'd1023, 1'b0, ALL_ZERO}
	};

	line_sensor_calibrate_threshold u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.channel      (channel),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.detected     (detected),
		.midpoint     (midpoint),
		.line_x       (line_x),
		.line_y       (line_y),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #2ns clk = ~clk;

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		end
	endtask

	// Mirror one sample into the calibration state and form its result
	function automatic line_result_t apply_sample(op_t op, logic [CHAN_W-1:0] ch,
			logic [DATA_W-1:0] raw);
		line_result_t r;
		logic [DATA_W-1:0] s;
		logic hit;
		logic in_range;
		int c;
		s = raw & SAMPLE_MASK;
		c = int'(ch);
		in_range = (c < CHANNELS);
		hit = 1'b0;
		if (op == OP_END) begin
			seeded_ch = '0;
		end else if (in_range && op == OP_CAL) begin
			// first sample seeds both bounds; later ones widen one side only
			if (!seeded_ch[c]) begin
				hi_cal[c] = s;
				lo_cal[c] = s;
				seeded_ch[c] = 1'b1;
			end else if (s > hi_cal[c]) begin
				hi_cal[c] = s;
			end else if (s < lo_cal[c]) begin
				lo_cal[c] = s;
			end
			mid_cal[c] = DATA_W'((int'(hi_cal[c]) + int'(lo_cal[c])) / 2);
		end else if (in_range && op == OP_LOAD) begin
			mid_cal[c] = s;
		end else if (in_range && op == OP_DETECT) begin
			// signed compare, so a margin above the midpoint never hits
			hit = (int'(s) <= int'(mid_cal[c]) - int'(margin_val));
			if (c <= 8) x_bits[c] = hit;
			if (c == 4) y_bits[4] = hit;
			if (c >= 9 && c <= 12) y_bits[c - 9] = hit;
			if (c >= 13 && c <= 16) y_bits[c - 8] = hit;
		end
		r.detected = hit;
		r.midpoint = in_range ? mid_cal[c] : '0;
		r.line_x = x_bits;
		r.line_y = y_bits;
		return r;
	endfunction

	// Drive one sample until its transfer, then record what it should produce
	task automatic push_sample(op_t op, logic [CHAN_W-1:0] ch, logic [DATA_W-1:0] s,
			bit typed, line_result_t want);
		line_result_t calc;
		item_valid <= 1'b1;
		operation <= op;
		channel <= ch;
		sample <= s;
		do @(posedge clk); while (!item_ready);
		calc = apply_sample(op, ch, s);
		pending_results.push_back(typed ? want : calc);
		op_seen[int'(op)]++;
		if (calc.detected) hits++;
	endtask

	task automatic maybe_idle_input();
		int n;
		if (!calm && $urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 12);
			item_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Mostly calibrate and detect near the live threshold; some loads, ends and junk channels
	task automatic pick_random_sample(output op_t op, output logic [CHAN_W-1:0] ch,
			output logic [DATA_W-1:0] s);
		int pick;
		int c;
		int thr;
		int jitter;
		pick = $urandom_range(0, 99);
		c = $urandom_range(0, CHANNELS - 1);
		ch = CHAN_W'(c);
		s = DATA_W'($urandom);
		op = OP_CAL;
		if (pick < 75 && pick >= 40) begin
			op = OP_DETECT;
			if ($urandom_range(0, 1) == 0) begin
				jitter = $urandom_range(0, 6);
				thr = int'(mid_cal[c]) - int'(margin_val) + jitter - 3;
				if (thr < 0) thr = 0;
				if (thr > SAMPLE_MAX) thr = SAMPLE_MAX;
				s = DATA_W'(thr);
			end
		end else if (pick >= 75 && pick < 83) begin
			op = OP_LOAD;
		end else if (pick >= 83 && pick < 90) begin
			op = OP_END;
			ch = CHAN_W'($urandom);
		end else if (pick >= 90) begin
			op = op_t'($urandom_range(0, 3));
			ch = CHAN_W'($urandom_range(CHANNELS, (1 << CHAN_W) - 1));
		end
	endtask

	// Margin write and readback, only once the block has drained
	task automatic write_margin(logic [PDATA_W-1:0] value);
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MARGIN_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		margin_val = value[DATA_W-1:0];
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[DATA_W-1:0] !== margin_val) begin
			report_mismatch("margin readback", 32'(prdata[DATA_W-1:0]), 32'(margin_val));
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side stalls in bursts
	always @(posedge clk) begin
		if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
			result_ready <= (ready_hold == 1);
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			ready_hold <= $urandom_range(1, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Result check and watchdog
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					report_mismatch("result transfer with none pending", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (detected !== want.detected)
						report_mismatch("detected", 32'(detected), 32'(want.detected));
					if (midpoint !== want.midpoint)
						report_mismatch("midpoint", 32'(midpoint), 32'(want.midpoint));
					if (line_x !== want.line_x)
						report_mismatch("line_x", 32'(line_x), 32'(want.line_x));
					if (line_y !== want.line_y)
						report_mismatch("line_y", 32'(line_y), 32'(want.line_y));
				end
			end
			if ((item_valid && item_ready) || (result_valid && result_ready) || psel) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles, %0d results pending",
					quiet_cycles, pending_results.size());
				$display("line_sensor_calibrate_threshold_test: FAIL");
				$finish;
			end
		end
	end

	initial begin
		op_t op;
		logic [CHAN_W-1:0] ch;
		logic [DATA_W-1:0] s;
		logic [PDATA_W-1:0] wval;
		for (int i = 0; i < CHANNELS; i++) begin
			hi_cal[i] = '0;
			lo_cal[i] = '0;
			mid_cal[i] = '0;
		end
		seeded_ch = '0;
		x_bits = '0;
		y_bits = '0;
		margin_val = MARGIN_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset margin
		for (int k = 0; k < ROW_COUNT; k++) begin
			maybe_idle_input();
			push_sample(directed_rows[k].op, directed_rows[k].ch, directed_rows[k].s,
				directed_rows[k].typed, directed_rows[k].want);
		end

		// random phases: zero margin, full margin, a random one, back to reset value
		for (int phase = 0; phase < PHASES; phase++) begin
			wval = PDATA_W'($urandom);
			case (phase)
				0: wval[DATA_W-1:0] = '0;
				1: wval[DATA_W-1:0] = '1;
				2: wval[DATA_W-1:0] = DATA_W'($urandom_range(1, SAMPLE_MAX - 1));
				default: wval[DATA_W-1:0] = MARGIN_RESET;
			endcase
			margins_used[phase] = int'(wval[DATA_W-1:0]);
			write_margin(wval);
			calm = (phase == PHASES - 1);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				maybe_idle_input();
				pick_random_sample(op, ch, s);
				push_sample(op, ch, s, 1'b0, ALL_ZERO);
			end
		end

		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("samples: %0d calibrate, %0d detect, %0d end-calibration, %0d load; %0d hits",
			op_seen[OP_CAL], op_seen[OP_DETECT], op_seen[OP_END], op_seen[OP_LOAD], hits);
		$display("margins 10, %0d, %0d, %0d, %0d; %0d results checked, %0d mismatches",
			margins_used[0], margins_used[1], margins_used[2], margins_used[3],
			results_checked, mismatches);
		if (mismatches == 0) begin
			$display("line_sensor_calibrate_threshold_test: PASS");
		end else begin
			$display("line_sensor_calibrate_threshold_test: FAIL");
		end
		$finish;
	end

endmodule
